@@ src/rxcs_pkg.sv @@
package rxcs_pkg;

   localparam int RXCS_MAX_CHARS = 4096;

   localparam int CHAR_W   = 8;
   localparam int RADIX_W  = 6;
   localparam int KEY_W    = 8;
   localparam int ACC_W    = 9;
   localparam int SCORE_OUT_W = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;

   localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd1;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
   localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
   localparam logic [ACC_W-1:0]   ACC_SAT     = 9'd256;
   localparam logic [5:0]         DIGIT_NONE  = 6'd36;

   localparam logic [CSR_IDX_W-1:0] CSR_RADIX   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_XOR_KEY = 1'b1;

   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_OVER = 2'd1,
      STAT_BAD  = 2'd2
   } cand_status_type;

   typedef enum logic {
      CTRL_IDLE,
      CTRL_DIVIDE
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic div_step;
      logic div_finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_busy;
      logic message_end;
      logic div_done;
   } dp_status_type;

   // ASCII digit value: 0-9, then letters of either case give 10-35.
   function automatic logic [5:0] digit_of(input logic [CHAR_W-1:0] c);
      logic [5:0] d;
      d = DIGIT_NONE;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = 6'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h7a) begin
         d = 6'(c - 8'h61 + 8'd10);
      end else if (c >= 8'h41 && c <= 8'h5a) begin
         d = 6'(c - 8'h41 + 8'd10);
      end
      return d;
   endfunction

   // Plausibility weight of one decrypted byte, -1 to +3.
   function automatic logic signed [2:0] byte_score(input logic [7:0] b);
      logic signed [2:0] s;
      s = (b >= 8'd32 && b <= 8'd126) ? 3'sd1 : -3'sd1;
      if ((b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a)) begin
         s = s + 3'sd2;
      end else if (b == 8'd32) begin
         s = s + 3'sd1;
      end
      return s;
   endfunction

endpackage

@@ src/rxcs_req_if.sv @@
interface rxcs_req_if import rxcs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] ciphertext_char;
   logic              number_end;
   logic              message_end;

   modport source (output valid, output ciphertext_char, output number_end,
                   output message_end, input ready);
   modport sink   (input valid, input ciphertext_char, input number_end,
                   input message_end, output ready);
endinterface

@@ src/rxcs_rsp_if.sv @@
interface rxcs_rsp_if import rxcs_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic [7:0]                    plain_byte;
   logic [1:0]                    status;
   logic                          final_flag;
   logic signed [SCORE_OUT_W-1:0] final_score;

   modport source (output valid, output plain_byte, output status, output final_flag,
                   output final_score, input ready);
   modport sink   (input valid, input plain_byte, input status, input final_flag,
                   input final_score, output ready);
endinterface

@@ src/rxcs_csr_if.sv @@
interface rxcs_csr_if import rxcs_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/rxcs_ctrl.sv @@
module rxcs_ctrl import rxcs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type dp_stat,
   output ctrl_cmd_type  cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTRL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_ready      = 1'b0;
      cmd.accept     = 1'b0;
      cmd.div_step   = 1'b0;
      cmd.div_finish = 1'b0;
      case (state_ff)
         CTRL_IDLE: begin
            req_ready  = !dp_stat.out_busy;
            cmd.accept = req_valid && !dp_stat.out_busy;
            if (cmd.accept && dp_stat.message_end) begin
               state_in = CTRL_DIVIDE;
            end
         end
         CTRL_DIVIDE: begin
            if (dp_stat.div_done) begin
               cmd.div_finish = 1'b1;
               state_in       = CTRL_IDLE;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         default: begin
            state_in = CTRL_IDLE;
         end
      endcase
   end

`ifndef ASSERT_OFF
   a_no_accept_while_dividing: assert property (@(posedge clock) disable iff (reset)
      state_ff == CTRL_DIVIDE |-> !req_ready)
      else $error("input accepted while the divider is busy");

   a_finish_returns_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_finish |=> state_ff == CTRL_IDLE)
      else $error("controller did not return to idle after the final score");

   a_end_starts_divide: assert property (@(posedge clock) disable iff (reset)
      cmd.accept && dp_stat.message_end |=> state_ff == CTRL_DIVIDE)
      else $error("message end did not start the division");
`endif

endmodule

@@ src/rxcs_datapath.sv @@
module rxcs_datapath import rxcs_pkg::*; #(
   parameter int MAX_CHARS = RXCS_MAX_CHARS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ctrl_cmd_type                  cmd,
   output dp_status_type                 dp_stat,
   input  logic [CHAR_W-1:0]             in_char,
   input  logic                          in_number_end,
   input  logic                          in_message_end,
   input  logic                          csr_write,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_data,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [7:0]                    out_plain_byte,
   output logic [1:0]                    out_status,
   output logic                          out_final_flag,
   output logic signed [SCORE_OUT_W-1:0] out_final_score
);

   localparam int MAG_W   = $clog2(3 * MAX_CHARS + 1);
   localparam int SCORE_W = MAG_W + 1;
   localparam int CNT_W   = $clog2(MAX_CHARS + 1);
   localparam int DCNT_W  = $clog2(MAG_W + 1);
   localparam int WIDE_W  = SCORE_W + 1 + SCORE_OUT_W;

   // configuration
   logic [RADIX_W-1:0] radix_ff, radix_in;
   logic [KEY_W-1:0]   key_ff, key_in;

   // message state
   logic [ACC_W-1:0]          acc_ff, acc_in;
   logic signed [SCORE_W-1:0] score_ff, score_in;
   cand_status_type           status_ff, status_in;
   logic [CNT_W-1:0]          count_ff, count_in;

   // divider
   logic [RADIX_W-1:0] rem_ff, rem_in;
   logic [MAG_W-1:0]   quo_ff, quo_in;
   logic               neg_ff, neg_in;
   logic [DCNT_W-1:0]  dcnt_ff, dcnt_in;

   // result register
   logic                          valid_ff, valid_in;
   logic [7:0]                    plain_ff, plain_in;
   cand_status_type               ostat_ff, ostat_in;
   logic                          final_ff, final_in;
   logic signed [SCORE_OUT_W-1:0] fscore_ff, fscore_in;

   // per-item decode and accumulate
   logic [5:0]                digit_raw;
   logic                      bad_digit;
   logic [5:0]                digit;
   logic [14:0]               product;
   logic [15:0]               acc_sum;
   logic [ACC_W-1:0]          acc_next;
   cand_status_type           status_digit;
   cand_status_type           status_end;
   logic                      over;
   logic [7:0]                value;
   logic                      scored;
   logic signed [2:0]         weight;
   logic signed [SCORE_W-1:0] score_upd;
   logic [SCORE_W-1:0]        score_neg;
   logic                      is_end;

   // divider step and final score
   logic [7:0]                trial;
   logic signed [SCORE_W-1:0] quo_signed;
   logic signed [SCORE_W:0]   quo_scaled;
   logic [WIDE_W-1:0]         quo_wide;

   logic [RADIX_W-1:0] csr_radix;

   always_comb begin
      csr_radix = csr_data[RADIX_W-1:0];
      if (csr_radix < RADIX_MIN) begin
         csr_radix = RADIX_MIN;
      end else if (csr_radix > RADIX_MAX) begin
         csr_radix = RADIX_MAX;
      end
   end

   always_comb begin
      radix_in = radix_ff;
      key_in   = key_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_RADIX:   radix_in = csr_radix;
            CSR_XOR_KEY: key_in   = csr_data[KEY_W-1:0];
            default:     radix_in = radix_ff;
         endcase
      end
   end

   always_comb begin
      digit_raw    = digit_of(in_char);
      bad_digit    = digit_raw >= radix_ff;
      digit        = bad_digit ? 6'd0 : digit_raw;
      product      = {9'd0, radix_ff} * {6'd0, acc_ff};
      acc_sum      = {1'b0, product} + {10'd0, digit};
      acc_next     = (acc_sum > 16'd255) ? ACC_SAT : acc_sum[ACC_W-1:0];
      status_digit = (bad_digit && status_ff == STAT_OK) ? STAT_BAD : status_ff;
      over         = acc_next[ACC_W-1];
      value        = acc_next[7:0] ^ key_ff;
      status_end   = (over && status_digit == STAT_OK) ? STAT_OVER : status_digit;
      scored       = !over && (count_ff < CNT_W'(MAX_CHARS));
      weight       = byte_score(value);
      score_upd    = scored ? score_ff + {{(SCORE_W-3){weight[2]}}, weight} : score_ff;
      score_neg    = SCORE_W'(-score_upd);
      is_end       = in_number_end || in_message_end;
   end

   // Restoring division of the score magnitude by the radix, one bit a cycle.
   always_comb begin
      trial = {1'b0, rem_ff, quo_ff[MAG_W-1]} - {2'd0, radix_ff};
   end

   always_comb begin
      quo_signed = neg_ff ? SCORE_W'(-{1'b0, quo_ff}) : {1'b0, quo_ff};
      quo_scaled = (key_ff == '0) ? {quo_signed, 1'b0} : {quo_signed[SCORE_W-1], quo_signed};
      quo_wide   = {{SCORE_OUT_W{quo_scaled[SCORE_W]}}, quo_scaled};
   end

   always_comb begin
      acc_in    = acc_ff;
      score_in  = score_ff;
      status_in = status_ff;
      count_in  = count_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      neg_in    = neg_ff;
      dcnt_in   = dcnt_ff;
      valid_in  = valid_ff && !out_ready;
      plain_in  = plain_ff;
      ostat_in  = ostat_ff;
      final_in  = final_ff;
      fscore_in = fscore_ff;

      if (cmd.accept) begin
         if (in_message_end) begin
            acc_in    = '0;
            score_in  = '0;
            status_in = STAT_OK;
            count_in  = '0;
            rem_in    = '0;
            neg_in    = score_upd[SCORE_W-1];
            quo_in    = score_upd[SCORE_W-1] ? score_neg[MAG_W-1:0]
                                             : score_upd[MAG_W-1:0];
            dcnt_in   = DCNT_W'(MAG_W);
         end else if (in_number_end) begin
            acc_in    = '0;
            score_in  = score_upd;
            status_in = status_end;
            count_in  = scored ? count_ff + 1'b1 : count_ff;
         end else begin
            acc_in    = acc_next;
            status_in = status_digit;
         end
         if (is_end) begin
            plain_in  = over ? 8'd0 : value;
            ostat_in  = status_end;
            final_in  = in_message_end;
            fscore_in = '0;
            // The message-end result is released once the final score is ready.
            valid_in  = !in_message_end;
         end
      end

      if (cmd.div_step) begin
         if (!trial[7]) begin
            rem_in = trial[RADIX_W-1:0];
         end else begin
            rem_in = {rem_ff[RADIX_W-2:0], quo_ff[MAG_W-1]};
         end
         quo_in  = {quo_ff[MAG_W-2:0], !trial[7]};
         dcnt_in = dcnt_ff - 1'b1;
      end

      if (cmd.div_finish) begin
         fscore_in = (ostat_ff == STAT_OK) ? quo_wide[SCORE_OUT_W-1:0] : '0;
         valid_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff  <= RADIX_RESET;
         key_ff    <= '0;
         acc_ff    <= '0;
         score_ff  <= '0;
         status_ff <= STAT_OK;
         count_ff  <= '0;
         dcnt_ff   <= '0;
         valid_ff  <= 1'b0;
      end else begin
         radix_ff  <= radix_in;
         key_ff    <= key_in;
         acc_ff    <= acc_in;
         score_ff  <= score_in;
         status_ff <= status_in;
         count_ff  <= count_in;
         dcnt_ff   <= dcnt_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      neg_ff    <= neg_in;
      plain_ff  <= plain_in;
      ostat_ff  <= ostat_in;
      final_ff  <= final_in;
      fscore_ff <= fscore_in;
   end

   assign dp_stat.out_busy    = valid_ff && !out_ready;
   assign dp_stat.message_end = in_message_end;
   assign dp_stat.div_done    = dcnt_ff == '0;

   assign out_valid       = valid_ff;
   assign out_plain_byte  = plain_ff;
   assign out_status      = ostat_ff;
   assign out_final_flag  = final_ff;
   assign out_final_score = fscore_ff;

`ifndef ASSERT_OFF
   a_acc_saturates: assert property (@(posedge clock) disable iff (reset)
      acc_ff <= ACC_SAT)
      else $error("digit accumulator exceeded its saturation value");

   a_radix_in_range: assert property (@(posedge clock) disable iff (reset)
      radix_ff >= RADIX_MIN && radix_ff <= RADIX_MAX)
      else $error("radix register left its legal range");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_CHARS))
      else $error("scored byte count passed the length limit");

   a_finish_presents_final: assert property (@(posedge clock) disable iff (reset)
      cmd.div_finish |=> valid_ff && final_ff)
      else $error("final score not presented after division");
`endif

endmodule

@@ src/radix_xor_candidate_scorer_core.sv @@
// Channel  Port      Direction  Handshake    Payload
// input    req_chan  sink       valid/ready  ciphertext_char, number_end, message_end
// result   rsp_chan  source     valid/ready  plain_byte, status, final_flag, final_score
// config   csr_chan  sink       valid/ready  index (0 radix, 1 xor_key), data
//
// A character that does not end the message leaves its result, if any, in the output register
// the next cycle. A message-end character starts the one-bit-a-cycle divider, which divides the
// score magnitude by the radix over its M = $clog2(3*MAX_CHARS+1) bits (14 at the default);
// no item is accepted meanwhile.
// A held result stalls the input only while rsp_chan.ready is low.
// Reset is synchronous and restores radix 10, key 0 and an empty message.
module radix_xor_candidate_scorer_core import rxcs_pkg::*; #(
   parameter int MAX_CHARS = RXCS_MAX_CHARS
) (
   input  logic         clock,
   input  logic         reset,
   rxcs_req_if.sink     req_chan,
   rxcs_rsp_if.source   rsp_chan,
   rxcs_csr_if.sink     csr_chan
);

   ctrl_cmd_type  cmd;
   dp_status_type dp_stat;

   assign csr_chan.ready = 1'b1;

   rxcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .dp_stat   (dp_stat),
      .cmd       (cmd)
   );

   rxcs_datapath #(
      .MAX_CHARS (MAX_CHARS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .dp_stat         (dp_stat),
      .in_char         (req_chan.ciphertext_char),
      .in_number_end   (req_chan.number_end),
      .in_message_end  (req_chan.message_end),
      .csr_write       (csr_chan.valid),
      .csr_index       (csr_chan.index),
      .csr_data        (csr_chan.data),
      .out_valid       (rsp_chan.valid),
      .out_ready       (rsp_chan.ready),
      .out_plain_byte  (rsp_chan.plain_byte),
      .out_status      (rsp_chan.status),
      .out_final_flag  (rsp_chan.final_flag),
      .out_final_score (rsp_chan.final_score)
   );

endmodule
